// ----- sv/dll_pkg.sv -----
`timescale 1ns / 1ps

package dll_pkg;

  localparam int unsigned CMD_W  = 5;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR       = 5'd0,
    CMD_INS_FIRST   = 5'd1,
    CMD_INS_LAST    = 5'd2,
    CMD_CUR_FIRST   = 5'd3,
    CMD_CUR_LAST    = 5'd4,
    CMD_READ_FIRST  = 5'd5,
    CMD_READ_LAST   = 5'd6,
    CMD_DEL_FIRST   = 5'd7,
    CMD_DEL_LAST    = 5'd8,
    CMD_DEL_AFTER   = 5'd9,
    CMD_DEL_BEFORE  = 5'd10,
    CMD_INS_AFTER   = 5'd11,
    CMD_INS_BEFORE  = 5'd12,
    CMD_READ_CUR    = 5'd13,
    CMD_WRITE_CUR   = 5'd14,
    CMD_CUR_NEXT    = 5'd15,
    CMD_CUR_PREV    = 5'd16,
    CMD_QUERY       = 5'd17
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD1,
    S_EV1,
    S_RD2,
    S_EV2,
    S_WR1,
    S_WR2,
    S_DONE
  } state_e;

endpackage

// ----- sv/doubly_linked_list_with_cursor.sv -----
`timescale 1ns / 1ps

// Bounded doubly linked list of signed 32-bit values with a cursor.
// Input channel: in_valid_i / in_stall_o with cmd_i and value_in_i. An item is
// taken at a rising edge with in_valid_i high and in_stall_o low. The block
// works on one command at a time and holds in_stall_o high until it is done.
// Output channel: out_valid_o / out_stall_i with read_value_o, error_o,
// active_o and node_count_o; every command yields exactly one result item.
// After accept every command passes S_RD1 and S_EV1; a lookup then goes to
// S_DONE, deleting the first or last node adds S_WR1, an insert adds S_WR1
// and S_WR2, and deleting next to the cursor adds S_RD2, S_EV2 and S_WR1.
// Another command can be taken in the cycle after the result is registered.
// The extra steps come from the single read and write port of each node
// memory: an insert writes the new node in S_WR1 and its neighbors in S_WR2.
// A held result does not block acceptance of the next command; the sequencer
// waits only when a new result is ready and the previous one is still stalled.
// Reset empties the list, makes the cursor inactive and drops any pending
// result. The node memories are not cleared; bookkeeping only reads entries
// that were written before.
module doubly_linked_list_with_cursor #(
  parameter int unsigned NODES = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [dll_pkg::CMD_W-1:0]         cmd_i,
  input  logic signed [dll_pkg::DATA_W-1:0] value_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [dll_pkg::DATA_W-1:0] read_value_o,
  output logic                              error_o,
  output logic                              active_o,
  output logic [$clog2(NODES+1)-1:0]        node_count_o
);

  localparam int unsigned PW = $clog2(NODES + 1);
  localparam int unsigned IW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam logic [PW-1:0] NIL = PW'(NODES);

  // Node storage.
  logic [dll_pkg::DATA_W-1:0] val_mem [NODES];
  logic [PW-1:0]              nxt_mem [NODES];
  logic [PW-1:0]              prv_mem [NODES];
  logic [IW-1:0]              fs_mem  [NODES];

  dll_pkg::state_e state_q, state_d;

  logic [dll_pkg::CMD_W-1:0]  cmd_q, cmd_d;
  logic [dll_pkg::DATA_W-1:0] val_q, val_d;
  logic [PW-1:0] head_q, head_d, tail_q, tail_d, cur_q, cur_d;
  logic [PW-1:0] free_top_q, free_top_d, fresh_q, fresh_d;
  logic [PW-1:0] a_q, a_d, b_q, b_d, p_q, p_d, n_q, n_d;
  logic [dll_pkg::DATA_W-1:0] res_rd_q, res_rd_d;
  logic          res_err_q, res_err_d;

  logic                       out_vld_q, out_vld_d;
  logic [dll_pkg::DATA_W-1:0] out_rd_q;
  logic                       out_err_q, out_act_q;
  logic [PW-1:0]              out_cnt_q;

  logic [dll_pkg::DATA_W-1:0] val_rd_q;
  logic [PW-1:0]              nxt_rd_q, prv_rd_q;
  logic [IW-1:0]              fs_rd_q;

  logic                       val_we, nxt_we, prv_we, fs_we;
  logic [IW-1:0]              val_wa, nxt_wa, prv_wa, fs_wa;
  logic [dll_pkg::DATA_W-1:0] val_wd;
  logic [PW-1:0]              nxt_wd, prv_wd;
  logic [IW-1:0]              fs_wd;
  logic [IW-1:0]              rd_addr, fs_ra;

  logic          accept, out_ld, act, is_ins, ins_ok, pool_full;
  logic [PW-1:0] sel_ptr, ins_a, ins_b, del_p, count;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != dll_pkg::S_IDLE);
  assign out_ld    = (state_q == dll_pkg::S_DONE) && (!out_vld_q || !out_stall_i);
  assign act       = (cur_q != NIL);
  assign count     = fresh_q - free_top_q;
  assign pool_full = (free_top_q == '0) && (fresh_q == NIL);
  assign is_ins    = cmd_q inside {dll_pkg::CMD_INS_FIRST, dll_pkg::CMD_INS_LAST,
                                   dll_pkg::CMD_INS_AFTER, dll_pkg::CMD_INS_BEFORE};
  assign ins_ok    = (cmd_q inside {dll_pkg::CMD_INS_FIRST, dll_pkg::CMD_INS_LAST}) ||
                     (is_ins && act);

  // Node looked up in the first read cycle.
  always_comb begin
    case (cmd_q)
      dll_pkg::CMD_READ_FIRST, dll_pkg::CMD_DEL_FIRST: sel_ptr = head_q;
      dll_pkg::CMD_READ_LAST, dll_pkg::CMD_DEL_LAST:   sel_ptr = tail_q;
      default:                                         sel_ptr = cur_q;
    endcase
  end

  // Neighbors of a new node and the node to unlink, valid in S_EV1.
  always_comb begin
    ins_a = cur_q;
    ins_b = nxt_rd_q;
    del_p = sel_ptr;
    case (cmd_q)
      dll_pkg::CMD_INS_FIRST: begin
        ins_a = NIL;
        ins_b = head_q;
      end
      dll_pkg::CMD_INS_LAST: begin
        ins_a = tail_q;
        ins_b = NIL;
      end
      dll_pkg::CMD_INS_BEFORE: begin
        ins_a = prv_rd_q;
        ins_b = cur_q;
      end
      dll_pkg::CMD_DEL_AFTER:  del_p = nxt_rd_q;
      dll_pkg::CMD_DEL_BEFORE: del_p = prv_rd_q;
      default: ;
    endcase
  end

  assign rd_addr = (state_q == dll_pkg::S_RD2) ? p_q[IW-1:0] : sel_ptr[IW-1:0];
  assign fs_ra   = IW'(free_top_q - PW'(1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dll_pkg::S_IDLE: begin
        if (accept) state_d = dll_pkg::S_RD1;
      end
      dll_pkg::S_RD1: state_d = dll_pkg::S_EV1;
      dll_pkg::S_EV1: begin
        state_d = dll_pkg::S_DONE;
        if (ins_ok && !pool_full) begin
          state_d = dll_pkg::S_WR1;
        end else if ((cmd_q inside {dll_pkg::CMD_DEL_FIRST, dll_pkg::CMD_DEL_LAST}) &&
                     sel_ptr != NIL) begin
          state_d = dll_pkg::S_WR1;
        end else if ((cmd_q inside {dll_pkg::CMD_DEL_AFTER, dll_pkg::CMD_DEL_BEFORE}) &&
                     act && del_p != NIL) begin
          state_d = dll_pkg::S_RD2;
        end
      end
      dll_pkg::S_RD2: state_d = dll_pkg::S_EV2;
      dll_pkg::S_EV2: state_d = dll_pkg::S_WR1;
      dll_pkg::S_WR1: state_d = is_ins ? dll_pkg::S_WR2 : dll_pkg::S_DONE;
      dll_pkg::S_WR2: state_d = dll_pkg::S_DONE;
      dll_pkg::S_DONE: begin
        if (out_ld) state_d = dll_pkg::S_IDLE;
      end
      default: state_d = dll_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory ports.
  always_comb begin
    cmd_d      = cmd_q;
    val_d      = val_q;
    head_d     = head_q;
    tail_d     = tail_q;
    cur_d      = cur_q;
    free_top_d = free_top_q;
    fresh_d    = fresh_q;
    a_d        = a_q;
    b_d        = b_q;
    p_d        = p_q;
    n_d        = n_q;
    res_rd_d   = res_rd_q;
    res_err_d  = res_err_q;
    val_we = 1'b0;
    val_wa = cur_q[IW-1:0];
    val_wd = val_q;
    nxt_we = 1'b0;
    nxt_wa = n_q[IW-1:0];
    nxt_wd = b_q;
    prv_we = 1'b0;
    prv_wa = n_q[IW-1:0];
    prv_wd = a_q;
    fs_we  = 1'b0;
    fs_wa  = free_top_q[IW-1:0];
    fs_wd  = p_q[IW-1:0];

    case (state_q)
      dll_pkg::S_IDLE: begin
        if (accept) begin
          cmd_d     = cmd_i;
          val_d     = value_in_i;
          res_rd_d  = '0;
          res_err_d = 1'b0;
        end
      end
      dll_pkg::S_EV1: begin
        case (cmd_q)
          dll_pkg::CMD_CLEAR: begin
            free_top_d = '0;
            fresh_d    = '0;
            head_d     = NIL;
            tail_d     = NIL;
            cur_d      = NIL;
          end
          dll_pkg::CMD_CUR_FIRST: cur_d = head_q;
          dll_pkg::CMD_CUR_LAST:  cur_d = tail_q;
          dll_pkg::CMD_READ_FIRST, dll_pkg::CMD_READ_LAST, dll_pkg::CMD_READ_CUR: begin
            if (sel_ptr != NIL) res_rd_d = val_rd_q;
            else res_err_d = 1'b1;
          end
          dll_pkg::CMD_WRITE_CUR: begin
            val_we = act;
          end
          dll_pkg::CMD_CUR_NEXT: begin
            if (act) cur_d = nxt_rd_q;
          end
          dll_pkg::CMD_CUR_PREV: begin
            if (act) cur_d = prv_rd_q;
          end
          dll_pkg::CMD_DEL_FIRST, dll_pkg::CMD_DEL_LAST: begin
            p_d = sel_ptr;
            a_d = prv_rd_q;
            b_d = nxt_rd_q;
          end
          dll_pkg::CMD_DEL_AFTER, dll_pkg::CMD_DEL_BEFORE: begin
            p_d = del_p;
          end
          dll_pkg::CMD_INS_FIRST, dll_pkg::CMD_INS_LAST,
          dll_pkg::CMD_INS_AFTER, dll_pkg::CMD_INS_BEFORE: begin
            a_d = ins_a;
            b_d = ins_b;
            // Recycled nodes are used before untouched ones.
            if (ins_ok) begin
              if (free_top_q != '0) begin
                n_d        = PW'(fs_rd_q);
                free_top_d = free_top_q - PW'(1);
              end else if (fresh_q != NIL) begin
                n_d     = fresh_q;
                fresh_d = fresh_q + PW'(1);
              end else begin
                res_err_d = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      dll_pkg::S_EV2: begin
        a_d = prv_rd_q;
        b_d = nxt_rd_q;
      end
      dll_pkg::S_WR1: begin
        if (is_ins) begin
          val_we = 1'b1;
          val_wa = n_q[IW-1:0];
          nxt_we = 1'b1;
          prv_we = 1'b1;
        end else begin
          nxt_wa = a_q[IW-1:0];
          nxt_wd = b_q;
          prv_wa = b_q[IW-1:0];
          prv_wd = a_q;
          if (a_q == NIL) head_d = b_q;
          else nxt_we = 1'b1;
          if (b_q == NIL) tail_d = a_q;
          else prv_we = 1'b1;
          if (cur_q == p_q) cur_d = NIL;
          if (free_top_q != NIL) begin
            fs_we      = 1'b1;
            free_top_d = free_top_q + PW'(1);
          end
        end
      end
      dll_pkg::S_WR2: begin
        nxt_wa = a_q[IW-1:0];
        nxt_wd = n_q;
        prv_wa = b_q[IW-1:0];
        prv_wd = n_q;
        if (a_q == NIL) head_d = n_q;
        else nxt_we = 1'b1;
        if (b_q == NIL) tail_d = n_q;
        else prv_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_ld) out_vld_d = 1'b1;
    else if (!out_stall_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dll_pkg::S_IDLE;
      head_q     <= NIL;
      tail_q     <= NIL;
      cur_q      <= NIL;
      free_top_q <= '0;
      fresh_q    <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      cur_q      <= cur_d;
      free_top_q <= free_top_d;
      fresh_q    <= fresh_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    val_q     <= val_d;
    a_q       <= a_d;
    b_q       <= b_d;
    p_q       <= p_d;
    n_q       <= n_d;
    res_rd_q  <= res_rd_d;
    res_err_q <= res_err_d;
    if (out_ld) begin
      out_rd_q  <= res_rd_q;
      out_err_q <= res_err_q;
      out_act_q <= act;
      out_cnt_q <= count;
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[val_wa] <= val_wd;
    val_rd_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    nxt_rd_q <= nxt_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    prv_rd_q <= prv_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (fs_we) fs_mem[fs_wa] <= fs_wd;
    fs_rd_q <= fs_mem[fs_ra];
  end

  assign out_valid_o  = out_vld_q;
  assign read_value_o = out_rd_q;
  assign error_o      = out_err_q;
  assign active_o     = out_act_q;
  assign node_count_o = out_cnt_q;

  a_pool_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_top_q <= fresh_q) && (fresh_q <= NIL))
    else $error("free stack deeper than the nodes handed out");

  a_ends_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dll_pkg::S_IDLE) |-> ((head_q == NIL) == (tail_q == NIL)))
    else $error("head and tail disagree on an empty list");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dll_pkg::S_IDLE) |-> ((head_q == NIL) == (count == '0)))
    else $error("node count does not match the list");

  a_cursor_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dll_pkg::S_IDLE && act) |-> (count != '0))
    else $error("cursor active on an empty list");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == dll_pkg::S_DONE))
    else $error("result item raised outside the finishing step");

endmodule
